>>> rtl/acs_pkg.sv
// Shared types and constants for the accumulator CPU step core.
`timescale 1ns / 1ps
package acs_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    // item kinds
    localparam logic [1:0] OP_EXEC  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // instruction opcodes
    localparam logic [3:0] OPC_HALT  = 4'h0;
    localparam logic [3:0] OPC_NOT   = 4'h1;
    localparam logic [3:0] OPC_SHL   = 4'h2;
    localparam logic [3:0] OPC_ASR   = 4'h3;
    localparam logic [3:0] OPC_INC   = 4'h4;
    localparam logic [3:0] OPC_DEC   = 4'h5;
    localparam logic [3:0] OPC_JMP   = 4'h6;
    localparam logic [3:0] OPC_JZ    = 4'h7;
    localparam logic [3:0] OPC_LOAD  = 4'h8;
    localparam logic [3:0] OPC_STORE = 4'h9;
    localparam logic [3:0] OPC_ADD   = 4'hA;
    localparam logic [3:0] OPC_AND   = 4'hB;
    localparam logic [3:0] OPC_OR    = 4'hC;
    localparam logic [3:0] OPC_XOR   = 4'hD;
    localparam logic [3:0] OPC_OUT   = 4'hE;
    localparam logic [3:0] OPC_IN    = 4'hF;

    localparam logic [1:0] MODE_ASCII = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] addr;
        logic [7:0]  wbyte;
        logic [15:0] in_word;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

endpackage

>>> rtl/acs_front.sv
// Front end: takes input items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module acs_front import acs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_byte_value,
    input  logic [15:0] i_input_word,
    output t_queue_head o_head,
    input  logic        i_pop
);

    t_item      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_item      in_item;
    logic       push;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;

    // keep only the fields each kind of item needs
    always_comb begin
        in_item.kind    = i_operation;
        in_item.addr    = i_address;
        in_item.wbyte   = (i_operation == OP_WRITE) ? i_byte_value : 8'd0;
        in_item.in_word = (i_operation == OP_EXEC) ? i_input_word : 16'd0;
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/acs_back.sv
// Back end: sequencer, byte-wide memory, accumulator/pc and the result register.
`timescale 1ns / 1ps
module acs_back import acs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_queue_head        i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_halted,
    output logic               o_out_valid,
    output logic signed [15:0] o_out_value,
    output logic [1:0]         o_out_mode,
    output logic [11:0]        o_program_counter,
    output logic signed [15:0] o_accumulator,
    output logic [7:0]         o_read_data
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_F0   = 3'd2;
    localparam logic [2:0] S_F1   = 3'd3;
    localparam logic [2:0] S_O0   = 3'd4;
    localparam logic [2:0] S_ST1  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [MEM_AW-1:0] r_clr;
    t_item             r_item;
    logic [7:0]        r_lo;
    logic [7:0]        r_wlo;
    logic [15:0]       r_instr;
    logic [15:0]       r_acc;
    logic [11:0]       r_pc;
    logic [7:0]        r_mem [MEM_BYTES];
    logic [7:0]        r_mem_q;
    logic              r_o_valid;

    logic              mem_we;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_a;
    logic [7:0]        mem_wd;

    logic              out_free;
    logic              start;
    logic              emit;

    logic [15:0]       fetch_w;
    logic [3:0]        opc_f;
    logic [11:0]       opr_f;
    logic              is_load_f;
    logic              is_store_f;
    logic [3:0]        opc;
    logic [11:0]       opr;
    logic [11:0]       opr_p1;
    logic [11:0]       pc_p1;
    logic [15:0]       mword;
    logic signed [15:0] acc_s;

    logic [15:0]       x_acc;
    logic [11:0]       x_pc;
    logic              x_halt;
    logic              x_ov;
    logic [15:0]       x_oval;
    logic [1:0]        x_mode;
    logic [7:0]        x_rd;

    assign out_free = !r_o_valid || !i_stall;
    assign emit     = (r_state == S_DONE) && out_free;
    assign start    = i_head.valid && ((r_state == S_IDLE) || emit);
    assign o_pop    = start;

    // instruction word: low byte latched in F0, high byte straight off the memory
    assign fetch_w    = {r_mem_q, r_lo};
    assign opc_f      = fetch_w[15:12];
    assign opr_f      = fetch_w[11:0];
    assign is_load_f  = opc_f inside {OPC_LOAD, OPC_ADD, OPC_AND, OPC_OR, OPC_XOR};
    assign is_store_f = (opc_f == OPC_STORE);

    assign opc    = r_instr[15:12];
    assign opr    = r_instr[11:0];
    assign opr_p1 = opr + 12'd1;
    assign pc_p1  = r_pc + 12'd1;
    assign mword  = {r_mem_q, r_wlo};
    assign acc_s  = r_acc;

    // memory port
    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_a  = '0;
        mem_wd = 8'd0;
        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_a  = r_clr;
            end
            S_IDLE, S_DONE: begin
                if (start) begin
                    case (i_head.item.kind)
                        OP_EXEC: begin
                            mem_re = 1'b1;
                            // pc of the item being retired this cycle is not in r_pc yet
                            mem_a  = (r_state == S_DONE) ? x_pc[MEM_AW-1:0]
                                                         : r_pc[MEM_AW-1:0];
                        end
                        OP_WRITE: begin
                            mem_we = 1'b1;
                            mem_a  = i_head.item.addr[MEM_AW-1:0];
                            mem_wd = i_head.item.wbyte;
                        end
                        OP_READ: begin
                            mem_re = 1'b1;
                            mem_a  = i_head.item.addr[MEM_AW-1:0];
                        end
                        default: ;
                    endcase
                end
            end
            S_F0: begin
                mem_re = 1'b1;
                mem_a  = pc_p1[MEM_AW-1:0];
            end
            S_F1: begin
                if (is_load_f) begin
                    mem_re = 1'b1;
                    mem_a  = opr_f[MEM_AW-1:0];
                end else if (is_store_f) begin
                    mem_we = 1'b1;
                    mem_a  = opr_f[MEM_AW-1:0];
                    mem_wd = r_acc[7:0];
                end
            end
            S_O0: begin
                mem_re = 1'b1;
                mem_a  = opr_p1[MEM_AW-1:0];
            end
            S_ST1: begin
                mem_we = 1'b1;
                mem_a  = opr_p1[MEM_AW-1:0];
                mem_wd = r_acc[15:8];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_a] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_a];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == {MEM_AW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE, S_DONE: begin
                if (start) begin
                    n_state = (i_head.item.kind == OP_EXEC) ? S_F0 : S_DONE;
                end else if (emit) begin
                    n_state = S_IDLE;
                end
            end
            S_F0: n_state = S_F1;
            S_F1: begin
                if (is_load_f) begin
                    n_state = S_O0;
                end else if (is_store_f) begin
                    n_state = S_ST1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_O0:    n_state = S_DONE;
            S_ST1:   n_state = S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    function automatic logic signed [15:0] acs_s_shift(input logic signed [15:0] v,
                                                       input logic [3:0] sh);
        acs_s_shift = v >>> sh;
    endfunction

    // result of the item held in r_item
    always_comb begin
        x_acc  = r_acc;
        x_pc   = r_pc;
        x_halt = 1'b0;
        x_ov   = 1'b0;
        x_oval = 16'd0;
        x_mode = 2'd0;
        x_rd   = 8'd0;
        case (r_item.kind)
            OP_EXEC: begin
                x_pc = r_pc + 12'd2;
                case (opc)
                    OPC_HALT: x_halt = 1'b1;
                    OPC_NOT:  x_acc = ~r_acc;
                    OPC_SHL:  x_acc = (opr[11:4] != 8'd0) ? 16'd0 : (r_acc << opr[3:0]);
                    OPC_ASR:  x_acc = (opr[11:4] != 8'd0) ? {16{r_acc[15]}}
                                                          : 16'(acs_s_shift(acc_s, opr[3:0]));
                    OPC_INC:  x_acc = r_acc + 16'd1;
                    OPC_DEC:  x_acc = r_acc - 16'd1;
                    OPC_JMP:  x_pc = opr;
                    OPC_JZ: begin
                        if (r_acc == 16'd0) begin
                            x_pc = opr;
                        end
                    end
                    OPC_LOAD:  x_acc = mword;
                    OPC_STORE: ;
                    OPC_ADD:   x_acc = r_acc + mword;
                    OPC_AND:   x_acc = r_acc & mword;
                    OPC_OR:    x_acc = r_acc | mword;
                    OPC_XOR:   x_acc = r_acc ^ mword;
                    OPC_OUT: begin
                        x_ov   = 1'b1;
                        x_oval = r_acc;
                        x_mode = (opr >= 12'd2) ? MODE_ASCII : opr[1:0];
                    end
                    default:   x_acc = r_item.in_word;
                endcase
            end
            OP_READ: x_rd = r_mem_q;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_acc     <= 16'd0;
            r_pc      <= 12'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + MEM_AW'(1);
            end
            if (emit) begin
                r_acc     <= x_acc;
                r_pc      <= x_pc;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_item <= i_head.item;
        end
        if (r_state == S_F0) begin
            r_lo <= r_mem_q;
        end
        if (r_state == S_F1) begin
            r_instr <= fetch_w;
        end
        if (r_state == S_O0) begin
            r_wlo <= r_mem_q;
        end
        if (emit) begin
            o_halted          <= x_halt;
            o_out_valid       <= x_ov;
            o_out_value       <= x_oval;
            o_out_mode        <= x_mode;
            o_program_counter <= x_pc;
            o_accumulator     <= x_acc;
            o_read_data       <= x_rd;
        end
    end

    assign o_valid = r_o_valid;

endmodule

>>> rtl/accumulator_cpu_step_core.sv
// Execute items read the instruction low byte, then the high byte; a load or store moves
// two operand bytes (one memory byte a cycle). Write and read items move one byte each.
// Throughput is set by the single byte-wide memory port of the back end.
// Reset (synchronous, active low) clears acc and pc, then a clearing pass zeroes each of the
// 4096 memory bytes; items are queued but not executed until it finishes.
`timescale 1ns / 1ps
module accumulator_cpu_step_core import acs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic [11:0]        i_address,
    input  logic [7:0]         i_byte_value,
    input  logic [15:0]        i_input_word,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_halted,
    output logic               o_out_valid,
    output logic signed [15:0] o_out_value,
    output logic [1:0]         o_out_mode,
    output logic [11:0]        o_program_counter,
    output logic signed [15:0] o_accumulator,
    output logic [7:0]         o_read_data
);

    t_queue_head head;
    logic        pop;

    acs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .i_byte_value (i_byte_value),
        .i_input_word (i_input_word),
        .o_head       (head),
        .i_pop        (pop)
    );

    acs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_halted          (o_halted),
        .o_out_valid       (o_out_valid),
        .o_out_value       (o_out_value),
        .o_out_mode        (o_out_mode),
        .o_program_counter (o_program_counter),
        .o_accumulator     (o_accumulator),
        .o_read_data       (o_read_data)
    );

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_halt_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_halted && o_out_valid))
        else $error("halt and output flagged on one item");

    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_read_data != 8'd0)) |-> (!o_halted && !o_out_valid))
        else $error("read data on an executed item");
`endif

endmodule

>>> test/acs_checker.sv
// Result checker: predicts each accumulator CPU step and compares the core's results.
`timescale 1ns / 1ps
module acs_checker import acs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_operation,
    input  logic [11:0]        i_address,
    input  logic [7:0]         i_byte_value,
    input  logic [15:0]        i_input_word,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic               i_halted,
    input  logic               i_out_valid,
    input  logic signed [15:0] i_out_value,
    input  logic [1:0]         i_out_mode,
    input  logic [11:0]        i_program_counter,
    input  logic signed [15:0] i_accumulator,
    input  logic [7:0]         i_read_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output logic [11:0]        o_model_pc
);

    typedef struct packed {
        logic        halted;
        logic        out_valid;
        logic [15:0] out_value;
        logic [1:0]  out_mode;
        logic [11:0] pc;
        logic [15:0] acc;
        logic [7:0]  read_data;
    } step_result_t;

    logic [7:0]   mem_image [MEM_BYTES];
    logic [15:0]  acc_q;
    logic [11:0]  pc_q;
    step_result_t expected_results [$];
    int           failures = 0;
    int           reports = 0;

    // little-endian word, both byte addresses wrap at the memory size
    function automatic logic [15:0] fetch_word(int unsigned a);
        return {mem_image[(a + 1) % MEM_BYTES], mem_image[a % MEM_BYTES]};
    endfunction

    function automatic step_result_t execute_item(logic [1:0] op, logic [11:0] addr,
                                                  logic [7:0] bval, logic [15:0] word);
        step_result_t r;
        logic [15:0]  instr;
        logic [11:0]  operand;
        logic [11:0]  next_pc;
        r = '0;
        case (op)
            OP_EXEC: begin
                instr   = fetch_word(pc_q);
                operand = instr[11:0];
                next_pc = pc_q + 12'd2;
                case (instr[15:12])
                    OPC_HALT:  r.halted = 1'b1;
                    OPC_NOT:   acc_q = ~acc_q;
                    OPC_SHL:   acc_q = (operand >= 16) ? 16'h0000 : acc_q << operand;
                    OPC_ASR:   acc_q = (operand >= 16) ? {16{acc_q[15]}}
                                                       : 16'($signed(acc_q) >>> operand);
                    OPC_INC:   acc_q = acc_q + 16'd1;
                    OPC_DEC:   acc_q = acc_q - 16'd1;
                    OPC_JMP:   next_pc = operand;
                    OPC_JZ:    if (acc_q == 16'h0000) next_pc = operand;
                    OPC_LOAD:  acc_q = fetch_word(operand);
                    OPC_STORE: begin
                        mem_image[operand % MEM_BYTES]              = acc_q[7:0];
                        mem_image[(32'(operand) + 1) % MEM_BYTES] = acc_q[15:8];
                    end
                    OPC_ADD:   acc_q = acc_q + fetch_word(operand);
                    OPC_AND:   acc_q = acc_q & fetch_word(operand);
                    OPC_OR:    acc_q = acc_q | fetch_word(operand);
                    OPC_XOR:   acc_q = acc_q ^ fetch_word(operand);
                    OPC_OUT: begin
                        r.out_valid = 1'b1;
                        r.out_value = acc_q;
                        r.out_mode  = (operand >= 2) ? MODE_ASCII : operand[1:0];
                    end
                    default:   acc_q = word;
                endcase
                pc_q = next_pc;
            end
            OP_WRITE: mem_image[addr % MEM_BYTES] = bval;
            OP_READ:  r.read_data = mem_image[addr % MEM_BYTES];
            default: ;
        endcase
        r.pc  = pc_q;
        r.acc = acc_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        step_result_t got;
        step_result_t want;
        if (!i_rst_n) begin
            for (int a = 0; a < MEM_BYTES; a++) mem_image[a] = 8'h00;
            acc_q = '0;
            pc_q  = '0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(execute_item(i_operation, i_address,
                                                        i_byte_value, i_input_word));
            if (i_res_valid && !i_res_stall) begin
                got = {i_halted, i_out_valid, i_out_value, i_out_mode,
                       i_program_counter, i_accumulator, i_read_data};
                if (expected_results.size() == 0) begin
                    failures++;
                    if (reports < 10) begin
                        reports++;
                        $display("%0t: result with no item outstanding: pc %h acc %h",
                                 $realtime, got.pc, got.acc);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.halted !== want.halted || got.out_valid !== want.out_valid ||
                        got.out_value !== want.out_value || got.out_mode !== want.out_mode ||
                        got.pc !== want.pc || got.acc !== want.acc ||
                        got.read_data !== want.read_data) begin
                        failures++;
                        if (reports < 10) begin
                            reports++;
                            $display({"%0t: mismatch (exp/act) halted %b/%b out %b/%b ",
                                      "value %h/%h mode %0d/%0d pc %h/%h acc %h/%h rd %h/%h"},
                                     $realtime, want.halted, got.halted,
                                     want.out_valid, got.out_valid,
                                     want.out_value, got.out_value,
                                     want.out_mode, got.out_mode, want.pc, got.pc,
                                     want.acc, got.acc, want.read_data, got.read_data);
                        end
                    end
                end
            end
        end
        o_pending    <= expected_results.size();
        o_model_pc   <= pc_q;
        o_fail_count <= failures;
    end

endmodule

>>> test/tb.sv
// Top-level testbench: clock, reset, item stimulus and verdict for the accumulator CPU core.
`timescale 1ns / 1ps
module tb;
    import acs_pkg::*;

    localparam int          IDLE_LIMIT   = 20000;
    localparam int          RANDOM_ITEMS = 1450;
    localparam logic [11:0] DATA_BASE    = 12'h800;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic [1:0]         i_operation = OP_NONE;
    logic [11:0]        i_address = '0;
    logic [7:0]         i_byte_value = '0;
    logic [15:0]        i_input_word = '0;
    logic               o_stall;
    logic               o_valid;
    logic               o_halted;
    logic               o_out_valid;
    logic signed [15:0] o_out_value;
    logic [1:0]         o_out_mode;
    logic [11:0]        o_program_counter;
    logic signed [15:0] o_accumulator;
    logic [7:0]         o_read_data;

    int          fail_count;
    int          pending;
    logic [11:0] model_pc;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;

    accumulator_cpu_step_core dut (.*);

    acs_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_operation       (i_operation),
        .i_address         (i_address),
        .i_byte_value      (i_byte_value),
        .i_input_word      (i_input_word),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_halted          (o_halted),
        .i_out_valid       (o_out_valid),
        .i_out_value       (o_out_value),
        .i_out_mode        (o_out_mode),
        .i_program_counter (o_program_counter),
        .i_accumulator     (o_accumulator),
        .i_read_data       (o_read_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_model_pc        (model_pc)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // covers the memory clearing pass after reset and the longest random stalls
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [15:0] rand_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_item(input logic [1:0] op, input logic [11:0] addr,
                             input logic [7:0] bval, input logic [15:0] word);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_address    <= addr;
        i_byte_value <= bval;
        i_input_word <= word;
        @(posedge i_clk);
        while (!(i_valid && !o_stall)) @(posedge i_clk);
        if (op != OP_NONE) items_sent++;
    endtask

    task automatic put_word(input logic [11:0] addr, input logic [15:0] w);
        send_item(OP_WRITE, addr, w[7:0], rand_word());
        send_item(OP_WRITE, addr + 12'd1, w[15:8], rand_word());
    endtask

    initial begin
        int          target;
        int          n;
        logic [11:0] chunk_pc;
        logic [15:0] prog [6];
        logic [3:0]  opc;
        logic [11:0] operand;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty memory decodes as halt
        send_item(OP_EXEC, 12'h000, 8'h00, 16'h0000);
        send_item(OP_NONE, 12'hFFF, 8'hFF, 16'hFFFF);
        send_item(OP_WRITE, 12'hFFF, 8'hFF, 16'h0000);
        send_item(OP_READ, 12'hFFF, 8'h00, 16'hFFFF);
        put_word(12'h002, {OPC_IN, 12'h000});
        put_word(12'h004, {OPC_ASR, 12'd16});
        put_word(12'h006, {OPC_OUT, 12'hFFF});
        put_word(12'h008, {OPC_SHL, 12'd16});
        put_word(12'h00A, {OPC_JZ, 12'hFFE});
        put_word(12'hFFE, {OPC_INC, 12'h000});
        send_item(OP_EXEC, 12'h000, 8'h00, 16'h8000);
        // saturating shifts, ASCII output, taken branch, then pc wraps to zero
        repeat (5) send_item(OP_EXEC, 12'h000, 8'h00, 16'h0000);
        send_item(OP_EXEC, 12'hFFF, 8'hFF, 16'h0000);
        send_item(OP_EXEC, 12'h000, 8'h00, 16'h7FFF);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 83; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            target = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < target) begin
                if ($urandom_range(3) != 0) begin
                    // short program written at the current pc, then run
                    i_valid <= 1'b0;
                    @(negedge i_clk);
                    chunk_pc = model_pc;
                    @(posedge i_clk);
                    n = $urandom_range(6, 1);
                    for (int k = 0; k < n; k++) begin
                        opc = 4'($urandom_range(15));
                        // branches only at the end so the layout stays straight-line
                        while (k != n - 1 && (opc == OPC_JMP || opc == OPC_JZ))
                            opc = 4'($urandom_range(15));
                        operand = 12'($urandom);
                        case (opc)
                            OPC_SHL, OPC_ASR: begin
                                if ($urandom_range(3) != 0) operand = 12'($urandom_range(17));
                            end
                            OPC_OUT: begin
                                if ($urandom_range(3) != 0) operand = 12'($urandom_range(3));
                            end
                            OPC_JMP, OPC_JZ, OPC_LOAD, OPC_STORE,
                            OPC_ADD, OPC_AND, OPC_OR, OPC_XOR: begin
                                case ($urandom_range(3))
                                    0: operand = $urandom_range(1) ?
                                                 12'hFFF - 12'($urandom_range(1)) :
                                                 12'($urandom_range(1));
                                    1: operand = DATA_BASE | 12'($urandom_range(31));
                                    default: ;
                                endcase
                            end
                            default: ;
                        endcase
                        prog[k] = {opc, operand};
                    end
                    if ($urandom_range(1))
                        put_word(DATA_BASE | 12'($urandom_range(31)), rand_word());
                    for (int k = 0; k < n; k++) put_word(chunk_pc + 12'(2 * k), prog[k]);
                    for (int k = 0; k < n; k++)
                        send_item(OP_EXEC, 12'($urandom), 8'($urandom), rand_word());
                    if ($urandom_range(3) == 0)
                        send_item(OP_READ, DATA_BASE | 12'($urandom_range(33)),
                                  8'($urandom), 16'($urandom));
                end else begin
                    send_item(2'($urandom_range(3)), 12'($urandom), 8'($urandom),
                              rand_word());
                end
            end
        end

        i_valid   <= 1'b0;
        stall_pct = 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
